/* rtl/core/bli_pkg.sv */
`timescale 1ns / 1ps
package bli_pkg;

  // table sizes and value width
  localparam int MAX_X_POINTS = 16;
  localparam int MAX_Y_POINTS = 16;
  localparam int VALUE_WIDTH  = 16;

  // item kinds carried on in_tuser
  typedef enum logic [1:0] {
    OP_LOAD_X = 2'd0,
    OP_LOAD_Y = 2'd1,
    OP_LOAD_Z = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  localparam logic CFG_X_USED = 1'b0;
  localparam logic CFG_Y_USED = 1'b1;
  localparam int   CFG_WIDTH  = 5;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_XSRCH = 10'b0000000010,
    ST_YSRCH = 10'b0000000100,
    ST_FETCH = 10'b0000001000,
    ST_MUL   = 10'b0000010000,
    ST_DIVI  = 10'b0000100000,
    ST_DIV   = 10'b0001000000,
    ST_DIVF  = 10'b0010000000,
    ST_NEXT  = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;

endpackage

/* rtl/core/bli_ram.sv */
`timescale 1ns / 1ps
module bli_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/bilinear_lut_interp.sv */
`timescale 1ns / 1ps
// Bilinear lookup-table interpolator, signed fixed point.
// Input words (in_*): tuser carries the op (load x point, load y point, load
// grid value, query); tdata carries row_index, col_index, load_value, query_x,
// query_y from the lowest bit up. Loads give no result; each query gives one
// result word on out_* (interp_value in tdata, above_range in tuser).
// The configuration port sets the number of x and y axis points in use; write
// it only while the block is idle.
// Loads are taken one per cycle while no query is in work. A query scans the x
// axis then the y axis one point per cycle, reads the four grid values and both
// axis pairs, then runs three interpolations through one shared multiplier and
// one restoring divider of 2*VALUE_WIDTH+2 steps (skipped when the two points
// are equal), then registers its result. in_tready is low while a query is in
// work and returns together with out_tvalid, as its result is registered.
// The result is held in the output register until taken; the next word is
// accepted meanwhile, and a finished query waits in its last state while the
// receiver stalls. Reset returns the sequencer to idle, clears the output
// valid and sets both point counts to their maximum. Tables are undefined
// until loaded.
module bilinear_lut_interp
  import bli_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // row_index, col_index, load_value, query_x, query_y
  input  logic [55:0]            in_tdata,
  // op
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // interp_value
  output logic [VALUE_WIDTH-1:0] out_tdata,
  // above_range
  output logic                   out_tuser,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_WIDTH-1:0]   cfg_data
);

  localparam int XA = $clog2(MAX_X_POINTS);
  localparam int YA = $clog2(MAX_Y_POINTS);
  localparam int GA = XA + YA;
  localparam int W  = VALUE_WIDTH;
  localparam int PW = 2 * W + 2;   // product sum width
  localparam int DW = W + 1;       // divisor width
  localparam int CW = $clog2(PW + 1);
  localparam int XC = $clog2(MAX_X_POINTS + 1);
  localparam int YC = $clog2(MAX_Y_POINTS + 1);

  // field split
  logic [3:0]          f_row, f_col;
  logic signed [15:0]  f_val, f_qx, f_qy;
  assign f_row = in_tdata[3:0];
  assign f_col = in_tdata[7:4];
  assign f_val = in_tdata[23:8];
  assign f_qx  = in_tdata[39:24];
  assign f_qy  = in_tdata[55:40];

  state_t state_r, state_nxt;
  logic [CFG_WIDTH-1:0] xu_cfg_r, yu_cfg_r;
  logic [XC-1:0] xu, xi_r;
  logic [YC-1:0] yu, yi_r;
  logic [XA-1:0] xa_r, xb_r;
  logic [YA-1:0] ya_r, yb_r;
  logic          above_r;
  logic signed [W-1:0] qx_r, qy_r;
  logic signed [W-1:0] x0_r, x1_r, y0_r, y1_r;
  logic signed [W-1:0] z00_r, z10_r, z01_r, z11_r, r1_r, r2_r;
  logic [2:0]    fcnt_r;
  logic [1:0]    pass_r;
  logic [PW-1:0]        quo_r, rem_r;
  logic [DW-1:0]        den_r;
  logic                 neg_r;
  logic [CW-1:0]        dcnt_r;
  logic [1:0]           mph_r;
  logic signed [PW-1:0] acc_r;
  logic                 out_valid_r;
  logic [W-1:0]         out_data_r;
  logic                 out_above_r;
  logic                 out_load;

  // point counts clamped to 1..MAX
  always_comb begin
    if (xu_cfg_r == '0) xu = XC'(1);
    else if (32'(xu_cfg_r) > MAX_X_POINTS) xu = XC'(MAX_X_POINTS);
    else xu = XC'(xu_cfg_r);
    if (yu_cfg_r == '0) yu = YC'(1);
    else if (32'(yu_cfg_r) > MAX_Y_POINTS) yu = YC'(MAX_Y_POINTS);
    else yu = YC'(yu_cfg_r);
  end

  // tables
  logic          in_acc;
  op_t           op;
  logic          xw, yw, zw;
  logic [XA-1:0] xraddr;
  logic [YA-1:0] yraddr;
  logic [GA-1:0] graddr;
  logic [W-1:0]  xrd, yrd, grd;
  logic          row_ok, col_ok;

  assign in_tready = state_r == ST_IDLE;
  assign in_acc    = in_tvalid && in_tready;
  assign op        = op_t'(in_tuser);
  assign row_ok    = 32'(f_row) < MAX_X_POINTS;
  assign col_ok    = 32'(f_col) < MAX_Y_POINTS;
  assign xw = in_acc && op == OP_LOAD_X && row_ok;
  assign yw = in_acc && op == OP_LOAD_Y && col_ok;
  assign zw = in_acc && op == OP_LOAD_Z && row_ok && col_ok;

  bli_ram #(.WIDTH(W), .DEPTH(MAX_X_POINTS)) u_xram (
    .clk(clk), .we(xw), .waddr(f_row[XA-1:0]), .wdata(W'(f_val)),
    .raddr(xraddr), .rdata(xrd));
  bli_ram #(.WIDTH(W), .DEPTH(MAX_Y_POINTS)) u_yram (
    .clk(clk), .we(yw), .waddr(f_col[YA-1:0]), .wdata(W'(f_val)),
    .raddr(yraddr), .rdata(yrd));
  bli_ram #(.WIDTH(W), .DEPTH(MAX_X_POINTS * MAX_Y_POINTS)) u_gram (
    .clk(clk), .we(zw), .waddr({f_row[XA-1:0], f_col[YA-1:0]}), .wdata(W'(f_val)),
    .raddr(graddr), .rdata(grd));

  // read addresses: scan index during search, grid corners during fetch;
  // axis ports during fetch: x at xa then xb, y at ya then yb
  always_comb begin
    if (state_r == ST_XSRCH) xraddr = xi_r[XA-1:0];
    else if (state_r == ST_FETCH && fcnt_r >= 3'd2) xraddr = xb_r;
    else xraddr = xa_r;
    if (state_r == ST_FETCH) yraddr = fcnt_r >= 3'd4 ? yb_r : ya_r;
    else yraddr = yi_r[YA-1:0];
    case (fcnt_r[1:0])
      2'd0:    graddr = {xa_r, ya_r};
      2'd1:    graddr = {xb_r, ya_r};
      2'd2:    graddr = {xa_r, yb_r};
      default: graddr = {xb_r, yb_r};
    endcase
  end

  // search compare: data is for index xi_r-1 (registered read)
  logic x_hit, y_hit;
  assign x_hit = qx_r <= $signed(xrd);
  assign y_hit = qy_r <= $signed(yrd);

  // interpolation operands for the current pass
  logic signed [W-1:0] p0, p1, c, v0, v1;
  always_comb begin
    case (pass_r)
      2'd0:    begin p0 = x0_r; p1 = x1_r; c = qx_r; v0 = z00_r; v1 = z10_r; end
      2'd1:    begin p0 = x0_r; p1 = x1_r; c = qx_r; v0 = z01_r; v1 = z11_r; end
      default: begin p0 = y0_r; p1 = y1_r; c = qy_r; v0 = r1_r;  v1 = r2_r;  end
    endcase
  end

  // shared multiplier: one product per cycle, two phases
  logic signed [W:0]    mfa;
  logic signed [W-1:0]  mfb;
  logic signed [2*W:0]  mprod;
  always_comb begin
    if (mph_r == 2'd0) begin
      mfa = (W+1)'(p1) - (W+1)'(c);
      mfb = v0;
    end else begin
      mfa = (W+1)'(c) - (W+1)'(p0);
      mfb = v1;
    end
  end
  assign mprod = mfa * mfb;

  // divider step
  logic signed [W:0] dden;
  logic [PW:0]       trial;
  logic [PW-1:0]     rsh;
  assign dden  = (W+1)'(p1) - (W+1)'(p0);
  assign rsh   = {rem_r[PW-2:0], quo_r[PW-1]};
  assign trial = {1'b0, rsh} - {{(PW-DW+1){1'b0}}, den_r};

  // signed quotient and saturation
  logic signed [PW-1:0] qs;
  logic signed [W-1:0]  qsat;
  localparam logic signed [PW-1:0] VMAX = PW'((64'sd1 <<< (W - 1)) - 1);
  localparam logic signed [PW-1:0] VMIN = -VMAX - PW'(1);
  assign qs = neg_r ? -$signed(quo_r) : $signed(quo_r);
  always_comb begin
    if (qs > VMAX) qsat = W'(VMAX);
    else if (qs < VMIN) qsat = W'(VMIN);
    else qsat = W'(qs);
  end

  // result moves to the output register once that is free
  assign out_load = state_r == ST_OUT && (!out_valid_r || out_tready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && op == OP_QUERY) state_nxt = ST_XSRCH;
      ST_XSRCH: if (xi_r != '0 && (x_hit || xi_r == xu)) state_nxt = ST_YSRCH;
      ST_YSRCH: if (yi_r != '0 && (y_hit || yi_r == yu)) state_nxt = ST_FETCH;
      ST_FETCH: if (fcnt_r == 3'd5) state_nxt = ST_MUL;
      ST_MUL:   if (mph_r == 2'd1) state_nxt = ST_DIVI;
      ST_DIVI:  state_nxt = p0 == p1 ? ST_NEXT : ST_DIV;
      ST_DIV:   if (dcnt_r == CW'(PW - 1)) state_nxt = ST_DIVF;
      ST_DIVF:  state_nxt = ST_NEXT;
      ST_NEXT:  state_nxt = pass_r == 2'd2 ? ST_OUT : ST_MUL;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      xu_cfg_r    <= CFG_WIDTH'(16);
      yu_cfg_r    <= CFG_WIDTH'(16);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_X_USED) xu_cfg_r <= cfg_data;
        else yu_cfg_r <= cfg_data;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        qx_r <= W'(f_qx); qy_r <= W'(f_qy);
        xi_r <= '0; yi_r <= '0; above_r <= 1'b0;
        fcnt_r <= '0; pass_r <= '0; mph_r <= '0;
      end
      ST_XSRCH: begin
        if (xi_r != '0 && x_hit) begin
          xb_r <= XA'(xi_r - XC'(1));
          xa_r <= xi_r == XC'(1) ? '0 : XA'(xi_r - XC'(2));
        end else if (xi_r != '0 && xi_r == xu) begin
          xa_r <= XA'(xu - XC'(1)); xb_r <= XA'(xu - XC'(1));
          above_r <= 1'b1;
        end
        xi_r <= xi_r + XC'(1);
      end
      ST_YSRCH: begin
        if (yi_r != '0 && y_hit) begin
          yb_r <= YA'(yi_r - YC'(1));
          ya_r <= yi_r == YC'(1) ? '0 : YA'(yi_r - YC'(2));
        end else if (yi_r != '0 && yi_r == yu) begin
          ya_r <= YA'(yu - YC'(1)); yb_r <= YA'(yu - YC'(1));
          above_r <= 1'b1;
        end
        yi_r <= yi_r + YC'(1);
      end
      ST_FETCH: begin
        // reads are registered: data is captured at the step after its address; axis reads reuse ports
        case (fcnt_r)
          3'd1: begin z00_r <= grd; x0_r <= xrd; end
          3'd2: z10_r <= grd;
          3'd3: begin z01_r <= grd; end
          3'd4: z11_r <= grd;
          default: ;
        endcase
        fcnt_r <= fcnt_r + 3'd1;
      end
      ST_MUL: begin
        if (mph_r == 2'd0) acc_r <= PW'(mprod);
        else acc_r <= acc_r + PW'(mprod);
        mph_r <= mph_r + 2'd1;
      end
      ST_DIVI: begin
        neg_r  <= acc_r[PW-1] ^ dden[W];
        quo_r  <= acc_r[PW-1] ? PW'(-acc_r) : acc_r;
        rem_r  <= '0;
        den_r  <= dden[W] ? DW'(-dden) : DW'(dden);
        dcnt_r <= '0;
      end
      ST_DIV: begin
        if (!trial[PW]) begin
          rem_r <= trial[PW-1:0];
          quo_r <= {quo_r[PW-2:0], 1'b1};
        end else begin
          rem_r <= rsh;
          quo_r <= {quo_r[PW-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r + CW'(1);
      end
      ST_DIVF: begin
        // final pass leaves z in r1
        case (pass_r)
          2'd1:    r2_r <= qsat;
          default: r1_r <= qsat;
        endcase
      end
      ST_NEXT: begin
        if (p0 == p1) begin
          case (pass_r)
            2'd0:    r1_r <= v0;
            2'd1:    r2_r <= v0;
            default: ;
          endcase
        end
        pass_r <= pass_r + 2'd1;
        mph_r  <= '0;
      end
      ST_OUT: begin
        if (out_load) begin
          out_data_r  <= r1_r;
          out_above_r <= above_r;
        end
      end
      default: ;
    endcase
    // axis point pairs fetched alongside the grid
    if (state_r == ST_FETCH && fcnt_r == 3'd3) begin
      x1_r <= xrd; y0_r <= yrd;
    end
    if (state_r == ST_FETCH && fcnt_r == 3'd5) y1_r <= yrd;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_above_r;

  // checks
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_tready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |=> out_tvalid) else $error("result missing");
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> dcnt_r < CW'(PW)) else $error("divider overrun");

endmodule

/* sim/tb_bilinear_lut_interp.sv */
`timescale 1ns / 1ps
module tb_bilinear_lut_interp;
  import bli_pkg::*;

  localparam int NPTS      = 16;
  localparam int DRAIN_CYC = 250;
  localparam int LIMIT_CYC = 2000000;

  typedef struct {
    op_t               op;
    logic [3:0]        row;
    logic [3:0]        col;
    logic signed [15:0] val;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
  } word_t;

  typedef struct {
    logic [15:0] z;
    logic        above;
  } interp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  // mirror of the table contents and point counts
  logic signed [15:0] x_pts [NPTS];
  logic signed [15:0] y_pts [NPTS];
  logic signed [15:0] z_grid [NPTS*NPTS];
  logic [4:0] x_used_reg = 5'd16;
  logic [4:0] y_used_reg = 5'd16;

  word_t   word_q [$];
  interp_t interp_q [$];
  word_t   cur_word;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      err_cnt = 0;
  int      cyc_cnt = 0;
  int      hold_cnt = 0;
  logic    hold_go = 1'b0;

  bilinear_lut_interp u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > LIMIT_CYC) begin
      $display("[bilinear_lut_interp] ERROR");
      $finish;
    end
  end

  function automatic int eff_used(logic [4:0] used);
    if (used == 0) return 1;
    if (used > NPTS) return NPTS;
    return used;
  endfunction

  // first used point not below coord, paired with the one before
  function automatic logic find_span(logic signed [15:0] pts [NPTS], int used,
                                     logic signed [15:0] coord, output int lo, output int hi);
    for (int i = 0; i < used; i++) begin
      if (coord <= pts[i]) begin
        lo = (i == 0) ? 0 : i - 1;
        hi = i;
        return 1'b0;
      end
    end
    lo = used - 1;
    hi = used - 1;
    return 1'b1;
  endfunction

  function automatic longint lerp_sat(longint p0, longint p1, longint c, longint v0,
                                      longint v1);
    longint q;
    if (p0 == p1) return v0;
    q = ((p1 - c) * v0 + (c - p0) * v1) / (p1 - p0);
    if (q > 32767) return 32767;
    if (q < -32768) return -32768;
    return q;
  endfunction

  // update the mirror for one accepted word; queries give an expected result
  task automatic apply_word(word_t w);
    int xa, xb, ya, yb;
    logic ab;
    longint r1, r2, zz;
    interp_t res;
    case (w.op)
      OP_LOAD_X: x_pts[w.row] = w.val;
      OP_LOAD_Y: y_pts[w.col] = w.val;
      OP_LOAD_Z: z_grid[w.row*NPTS + w.col] = w.val;
      default: begin
        ab = find_span(x_pts, eff_used(x_used_reg), w.qx, xa, xb);
        ab = find_span(y_pts, eff_used(y_used_reg), w.qy, ya, yb) | ab;
        r1 = lerp_sat(x_pts[xa], x_pts[xb], w.qx, z_grid[xa*NPTS+ya], z_grid[xb*NPTS+ya]);
        r2 = lerp_sat(x_pts[xa], x_pts[xb], w.qx, z_grid[xa*NPTS+yb], z_grid[xb*NPTS+yb]);
        zz = lerp_sat(y_pts[ya], y_pts[yb], w.qy, r1, r2);
        res.z = zz[15:0];
        res.above = ab;
        interp_q.push_back(res);
      end
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) apply_word(cur_word);
      if (!in_tvalid || in_tready) begin
        if (word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_word = word_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {cur_word.qy, cur_word.qx, cur_word.val, cur_word.col,
                       cur_word.row};
          in_tuser <= cur_word.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_go) hold_cnt <= 400;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (interp_q.size() == 0) begin
        $error("result word with nothing expected: interp_value %0d", $signed(out_tdata));
        err_cnt++;
      end else begin
        if (out_tdata !== interp_q[0].z) begin
          $error("interp_value: expected %0d, got %0d", $signed(interp_q[0].z),
                 $signed(out_tdata));
          err_cnt++;
        end
        if (out_tuser !== interp_q[0].above) begin
          $error("above_range: expected %0b, got %0b", interp_q[0].above, out_tuser);
          err_cnt++;
        end
        void'(interp_q.pop_front());
      end
    end
    out_tready <= rst_n && hold_cnt == 0 && $urandom_range(99) >= recv_stall_pct;
  end

  task automatic push_word(op_t op, int row, int col, int val, int qx, int qy);
    word_t w;
    w.op = op;
    w.row = row[3:0];
    w.col = col[3:0];
    w.val = val[15:0];
    w.qx = qx[15:0];
    w.qy = qy[15:0];
    word_q.push_back(w);
  endtask

  function automatic int rnd16();
    return $signed(16'($urandom));
  endfunction

  task automatic push_load(op_t op, int row, int col, int val);
    push_word(op, row, col, val, rnd16(), rnd16());
  endtask

  task automatic push_query(int qx, int qy);
    push_word(OP_QUERY, $urandom_range(15), $urandom_range(15), rnd16(), qx, qy);
  endtask

  // wait until the block has gone quiet
  task automatic wait_quiet();
    do @(posedge clk);
    while (word_q.size() > 0 || in_tvalid || interp_q.size() > 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_WIDTH-1:0];
    if (idx == CFG_X_USED) x_used_reg = val[4:0];
    else y_used_reg = val[4:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ascending axis with random origin and spacing
  task automatic load_axis(op_t op);
    int v, stp;
    stp = ($urandom_range(3) == 0) ? 1 + $urandom_range(20) : 1 + $urandom_range(2100);
    v = -32768 + $urandom_range(32767 - 15 * stp);
    if ($urandom_range(3) == 0) v = -32768 + $urandom_range(65535 - 15 * stp);
    for (int i = 0; i < NPTS; i++) begin
      push_load(op, i, i, v);
      v += 1 + $urandom_range(stp - 1);
    end
  endtask

  // coordinate mostly within the axis span, sometimes at or past its ends
  function automatic int pick_coord(logic on_x, int used);
    int lo, hi, p, d;
    lo = 32767;
    hi = -32768;
    for (int i = 0; i < used; i++) begin
      p = on_x ? x_pts[i] : y_pts[i];
      if (p < lo) lo = p;
      if (p > hi) hi = p;
    end
    d = $urandom_range(300);
    case ($urandom_range(9))
      0: return rnd16();
      1: return on_x ? x_pts[$urandom_range(used - 1)] : y_pts[$urandom_range(used - 1)];
      2: return (lo - 1 - d < -32768) ? -32768 : lo - 1 - d;
      3: return (hi + 1 + d > 32767) ? 32767 : hi + 1 + d;
      default: return lo + $urandom_range(hi - lo);
    endcase
  endfunction

  task automatic random_phase(int n);
    int k;
    k = 0;
    while (k < n) begin
      case ($urandom_range(19))
        0: begin load_axis(OP_LOAD_X); k += NPTS; end
        1: begin load_axis(OP_LOAD_Y); k += NPTS; end
        2: begin
          // out-of-order axis point
          push_load($urandom_range(1) ? OP_LOAD_X : OP_LOAD_Y, $urandom_range(15),
                    $urandom_range(15), rnd16());
          k++;
        end
        3, 4, 5: begin
          push_load(OP_LOAD_Z, $urandom_range(15), $urandom_range(15), rnd16());
          k++;
        end
        default: begin
          push_query(pick_coord(1'b1, eff_used(x_used_reg)),
                     pick_coord(1'b0, eff_used(y_used_reg)));
          k++;
        end
      endcase
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every table entry so no query reads an unwritten one
    load_axis(OP_LOAD_X);
    load_axis(OP_LOAD_Y);
    for (int r = 0; r < NPTS; r++)
      for (int c = 0; c < NPTS; c++)
        push_load(OP_LOAD_Z, r, c, rnd16());
    wait_quiet();

    // directed: extremes of values and coordinates, exact points, clamping
    push_load(OP_LOAD_Z, 0, 0, 32767);
    push_load(OP_LOAD_Z, 15, 15, -32768);
    push_load(OP_LOAD_Z, 1, 0, -32768);
    push_load(OP_LOAD_Z, 0, 1, 32767);
    push_query(-32768, -32768);
    push_query(32767, 32767);
    push_query(-32768, 32767);
    push_query(32767, -32768);
    push_query(0, 0);
    push_word(OP_QUERY, 0, 0, 0, x_pts[0], y_pts[0]);
    push_word(OP_QUERY, 15, 15, -1, x_pts[15], y_pts[15]);
    push_word(OP_QUERY, 0, 0, 0, x_pts[7], y_pts[8]);
    push_query((x_pts[2] + x_pts[3]) / 2, (y_pts[5] + y_pts[6]) / 2);
    // equal neighbouring points; the query at the lower one uses the pair below it
    push_load(OP_LOAD_X, 4, 0, x_pts[3]);
    push_load(OP_LOAD_Y, 0, 10, y_pts[9]);
    push_query(x_pts[3], y_pts[9]);
    // first x pair rewritten, then made descending; the last query falls on point 0 alone
    push_load(OP_LOAD_X, 1, 0, 32767);
    push_load(OP_LOAD_X, 0, 0, -32768);
    push_load(OP_LOAD_X, 1, 0, -32767);
    push_query(-32768 + 1, 0);
    push_load(OP_LOAD_X, 0, 0, 32767);
    push_query(100, y_pts[1]);
    wait_quiet();
    load_axis(OP_LOAD_X);
    load_axis(OP_LOAD_Y);
    wait_quiet();

    // receiver holds off while the sender keeps offering
    @(negedge clk) hold_go = 1'b1;
    @(negedge clk) hold_go = 1'b0;
    for (int i = 0; i < 20; i++) push_query(pick_coord(1'b1, 16), pick_coord(1'b0, 16));
    wait_quiet();

    // sender idle rarely, receiver stalls a lot
    send_idle_pct = 26;
    recv_stall_pct = 84;
    write_reg(CFG_X_USED, 1);
    write_reg(CFG_Y_USED, 16);
    random_phase(100);
    wait_quiet();
    write_reg(CFG_X_USED, 0);
    write_reg(CFG_Y_USED, 31);
    random_phase(100);
    wait_quiet();

    send_idle_pct = 84;
    recv_stall_pct = 26;
    write_reg(CFG_X_USED, 31);
    write_reg(CFG_Y_USED, 0);
    random_phase(100);
    wait_quiet();
    write_reg(CFG_X_USED, 5);
    write_reg(CFG_Y_USED, 9);
    random_phase(100);
    wait_quiet();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(CFG_X_USED, 16);
    write_reg(CFG_Y_USED, 1);
    random_phase(100);
    wait_quiet();
    write_reg(CFG_X_USED, 16);
    write_reg(CFG_Y_USED, 16);
    random_phase(100);
    wait_quiet();

    if (err_cnt == 0) begin
      $display("[bilinear_lut_interp] OK");
    end else begin
      $display("[bilinear_lut_interp] ERROR");
    end
    $finish;
  end

endmodule
